// ===== src/fdx_pkg.sv =====
// Shared types, constants and helper functions for the filename date extractor.
package fdx_pkg;

    // Window geometry and name-length thresholds
    localparam int WIN_LEN = 10;
    localparam int SEP_MIN = 10;
    localparam int CMP_MIN = 8;

    // Character codes
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_USCORE = 8'h5F;

    // Date limits
    localparam logic [13:0] YEAR_MIN  = 14'd1900;
    localparam logic [13:0] YEAR_MAX  = 14'd2100;
    localparam logic [6:0]  MONTH_MIN = 7'd1;
    localparam logic [6:0]  MONTH_MAX = 7'd12;
    localparam logic [6:0]  DAY_MIN   = 7'd1;
    localparam logic [6:0]  DAY_MAX   = 7'd31;

    // One decoded character held in a window cell
    typedef struct packed {
        logic       dig;
        logic       sep;
        logic [3:0] val;
    } t_char_info;

    // Packed date: year, month, day
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_date;

    // Pattern check results for the current window
    typedef struct packed {
        logic  sep_hit;
        t_date sep_date;
        logic  cmp_hit;
        t_date cmp_date;
    } t_match;

    // Classify one input byte
    function automatic t_char_info decode_char(input logic [7:0] c);
        t_char_info info;
        logic [7:0] diff;
        diff     = c - CHAR_ZERO;
        info.dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        info.sep = (c == CHAR_DASH) || (c == CHAR_USCORE);
        info.val = diff[3:0];
        return info;
    endfunction

    // Two decimal digits to a value 0..99
    function automatic logic [6:0] pair_val(input logic [3:0] hi, input logic [3:0] lo);
        logic [6:0] hi_w;
        hi_w = {3'b000, hi};
        return (hi_w << 3) + (hi_w << 1) + {3'b000, lo};
    endfunction

    // Four decimal digits to a value 0..9999
    function automatic logic [13:0] year_val(input logic [3:0] d0, input logic [3:0] d1,
                                             input logic [3:0] d2, input logic [3:0] d3);
        return ({10'd0, d0} * 14'd1000) + ({10'd0, d1} * 14'd100) +
               ({10'd0, d2} * 14'd10) + {10'd0, d3};
    endfunction

endpackage

// ===== src/fdx_cell.sv =====
// One window cell: holds a decoded character and passes it to its older neighbor.
module fdx_cell
    import fdx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_shift,
    input  t_char_info i_data,
    output t_char_info o_data
);

    t_char_info r_data;

    // Advance the window by one character per accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== src/fdx_check.sv =====
// Pattern check over the character window: separated and compact date forms.
module fdx_check
    import fdx_pkg::*;
(
    input  t_char_info [WIN_LEN-1:0] i_win,
    output t_match                   o_match
);

    logic        sep_shape;
    logic        cmp_shape;
    logic [13:0] sep_year;
    logic [6:0]  sep_month;
    logic [6:0]  sep_day;
    logic [13:0] cmp_year;
    logic [6:0]  cmp_month;
    logic [6:0]  cmp_day;

    // Separated form over entries 0..9, compact form over entries 2..9
    always_comb begin
        sep_shape = i_win[0].dig && i_win[1].dig && i_win[2].dig && i_win[3].dig &&
                    i_win[4].sep && i_win[5].dig && i_win[6].dig && i_win[7].sep &&
                    i_win[8].dig && i_win[9].dig;
        cmp_shape = i_win[2].dig && i_win[3].dig && i_win[4].dig && i_win[5].dig &&
                    i_win[6].dig && i_win[7].dig && i_win[8].dig && i_win[9].dig;

        sep_year  = year_val(i_win[0].val, i_win[1].val, i_win[2].val, i_win[3].val);
        sep_month = pair_val(i_win[5].val, i_win[6].val);
        sep_day   = pair_val(i_win[8].val, i_win[9].val);

        cmp_year  = year_val(i_win[2].val, i_win[3].val, i_win[4].val, i_win[5].val);
        cmp_month = pair_val(i_win[6].val, i_win[7].val);
        cmp_day   = pair_val(i_win[8].val, i_win[9].val);

        o_match.sep_hit = sep_shape &&
                          (sep_month >= MONTH_MIN) && (sep_month <= MONTH_MAX) &&
                          (sep_day >= DAY_MIN) && (sep_day <= DAY_MAX);
        o_match.sep_date.year  = sep_year;
        o_match.sep_date.month = sep_month[3:0];
        o_match.sep_date.day   = sep_day[4:0];

        o_match.cmp_hit = cmp_shape &&
                          (cmp_year >= YEAR_MIN) && (cmp_year <= YEAR_MAX) &&
                          (cmp_month >= MONTH_MIN) && (cmp_month <= MONTH_MAX) &&
                          (cmp_day >= DAY_MIN) && (cmp_day <= DAY_MAX);
        o_match.cmp_date.year  = cmp_year;
        o_match.cmp_date.month = cmp_month[3:0];
        o_match.cmp_date.day   = cmp_day[4:0];
    end

endmodule

// ===== src/filename_date_extractor_unit.sv =====
// Top level of the filename date extractor: cell chain, check stage, result register.
// A final character passes the cell chain and check stage, then loads the result register.
// Throughput: one character per cycle; the ten-cell window shifts on every accepted character.
// The input stalls only while a final character in the check stage waits on an untaken result.
// Reset (i_rst_n low at a clock edge) empties the pipeline, the latches and the output.
module filename_date_extractor_unit
    import fdx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [13:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day
);

    t_char_info [WIN_LEN-1:0] win;
    t_char_info [WIN_LEN-1:0] cell_in;
    t_match                   match;

    logic        accept;
    logic        stall;
    logic        adv;
    logic        sep_now;
    logic        cmp_now;
    t_date       sel_date;

    logic [3:0]  r_cnt;
    logic [3:0]  n_cnt;
    logic        r_chk_valid;
    logic        r_chk_last;
    logic        r_chk_ge8;
    logic        r_chk_ge10;
    logic        r_sep_valid;
    t_date       r_sep_date;
    logic        r_cmp_valid;
    t_date       r_cmp_date;
    logic        r_out_valid;
    logic        r_found;
    t_date       r_out_date;

    // Handshake: hold the input only when a final character waits on a full output
    assign stall   = r_chk_valid && r_chk_last && r_out_valid && !i_ready;
    assign o_ready = !stall;
    assign accept  = i_valid && o_ready;
    assign adv     = r_chk_valid && !stall;

    // Feed the chain: newest character enters the top cell
    always_comb begin
        for (int k = 0; k < WIN_LEN - 1; k++) begin
            cell_in[k] = win[k + 1];
        end
        cell_in[WIN_LEN - 1] = decode_char(i_char_code);
    end

    // Build the window from a row of identical cells
    for (genvar g = 0; g < WIN_LEN; g++) begin : g_cell
        fdx_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (accept),
            .i_data  (cell_in[g]),
            .o_data  (win[g])
        );
    end

    fdx_check u_check (
        .i_win   (win),
        .o_match (match)
    );

    // Count characters of the current name, saturating at the window length
    always_comb begin
        n_cnt = (r_cnt == 4'(WIN_LEN)) ? r_cnt : r_cnt + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_cnt <= i_last_char ? 4'd0 : n_cnt;
            end
            r_chk_valid <= stall || accept;
        end
    end

    // Capture name-position flags alongside the shifted window
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_chk_last <= i_last_char;
            r_chk_ge8  <= n_cnt >= 4'(CMP_MIN);
            r_chk_ge10 <= n_cnt >= 4'(SEP_MIN);
        end
    end

    // Combine stored first matches with this cycle's matches
    always_comb begin
        sep_now = r_sep_valid || (r_chk_ge10 && match.sep_hit);
        cmp_now = r_cmp_valid || (r_chk_ge8 && match.cmp_hit);
        if (r_sep_valid) begin
            sel_date = r_sep_date;
        end else if (r_chk_ge10 && match.sep_hit) begin
            sel_date = match.sep_date;
        end else if (r_cmp_valid) begin
            sel_date = r_cmp_date;
        end else if (r_chk_ge8 && match.cmp_hit) begin
            sel_date = match.cmp_date;
        end else begin
            sel_date = '0;
        end
    end

    // Latch the earliest match of each form; drop both at end of name
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_valid <= 1'b0;
            r_cmp_valid <= 1'b0;
        end else if (adv) begin
            if (r_chk_last) begin
                r_sep_valid <= 1'b0;
                r_cmp_valid <= 1'b0;
            end else begin
                r_sep_valid <= sep_now;
                r_cmp_valid <= cmp_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && !r_sep_valid) begin
            r_sep_date <= match.sep_date;
        end
        if (adv && !r_cmp_valid) begin
            r_cmp_date <= match.cmp_date;
        end
    end

    // Result register: load on the final character, release when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_chk_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_chk_last) begin
            r_found    <= sep_now || cmp_now;
            r_out_date <= sel_date;
        end
    end

    assign o_valid = r_out_valid;
    assign o_found = r_found;
    assign o_year  = r_out_date.year;
    assign o_month = r_out_date.month;
    assign o_day   = r_out_date.day;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the filename date extractor: directed names, then random names.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF   = 4;
    localparam int CYCLE_CAP  = 200000;
    localparam int DRAIN_WAIT = 6;
    localparam int RAND_CHARS = 550;
    localparam int MAX_NAME   = 40;
    localparam int NUM_ROWS   = 5;
    localparam int WIN        = 10;
    localparam int SEP_LEN    = 10;
    localparam int CMP_LEN    = 8;
    localparam logic [7:0] ASC_ZERO  = 8'h30;
    localparam logic [7:0] ASC_NINE  = 8'h39;
    localparam logic [7:0] ASC_DASH  = 8'h2D;
    localparam logic [7:0] ASC_UNDER = 8'h5F;
    localparam logic [7:0] ASC_LOW_A = 8'h61;

    typedef struct packed {
        logic        found;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_result_t;

    // One directed name: text right-justified, first character in the highest used byte
    typedef struct packed {
        logic [79:0]  text;
        logic [3:0]   len;
        logic         typed;
        date_result_t want;
    } name_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_char_code = 8'h00;
    logic        i_last_char = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_found;
    logic [13:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;

    filename_date_extractor_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_found     (o_found),
        .o_year      (o_year),
        .o_month     (o_month),
        .o_day       (o_day)
    );

    // Date predictor state
    logic [7:0]   win_bytes [WIN];
    int           seen_cnt;
    logic         sep_hit;
    logic         cmp_hit;
    date_result_t sep_date;
    date_result_t cmp_date;

    date_result_t expected_dates [$];
    date_result_t mon_want;
    name_row_t    dir_rows [NUM_ROWS];
    logic [7:0]   name_buf [MAX_NAME];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int names_sent = 0;
    int chars_sent = 0;
    int results_seen = 0;
    int dates_found = 0;
    int cycle_cnt = 0;

    always #CLK_HALF i_clk = ~i_clk;

    function automatic bit is_digit(input logic [7:0] c);
        return (c >= ASC_ZERO) && (c <= ASC_NINE);
    endfunction

    function automatic bit is_sep(input logic [7:0] c);
        return (c == ASC_DASH) || (c == ASC_UNDER);
    endfunction

    function automatic int digit_at(input int k);
        return int'(win_bytes[k]) - int'(ASC_ZERO);
    endfunction

    function automatic void clear_predictor();
        int k;
        for (k = 0; k < WIN; k++) win_bytes[k] = 8'h00;
        seen_cnt = 0;
        sep_hit  = 1'b0;
        cmp_hit  = 1'b0;
        sep_date = '0;
        cmp_date = '0;
    endfunction

    // Advance the predictor by one character; return 1 when a result is due
    function automatic bit date_after_char(input logic [7:0] c, input logic last,
                                           output date_result_t res);
        int k, y, m, d;
        bit ok;
        for (k = 0; k < WIN - 1; k++) win_bytes[k] = win_bytes[k + 1];
        win_bytes[WIN - 1] = c;
        if (seen_cnt < WIN) seen_cnt++;

        // Separated form spans the whole window
        if (!sep_hit && seen_cnt >= SEP_LEN) begin
            ok = is_sep(win_bytes[4]) && is_sep(win_bytes[7]);
            for (k = 0; k < WIN; k++) begin
                if (k != 4 && k != 7 && !is_digit(win_bytes[k])) ok = 1'b0;
            end
            if (ok) begin
                y = digit_at(0) * 1000 + digit_at(1) * 100 + digit_at(2) * 10 + digit_at(3);
                m = digit_at(5) * 10 + digit_at(6);
                d = digit_at(8) * 10 + digit_at(9);
                if (m >= 1 && m <= 12 && d >= 1 && d <= 31) begin
                    sep_hit  = 1'b1;
                    sep_date = '{1'b1, 14'(y), 4'(m), 5'(d)};
                end
            end
        end

        // Compact form covers the newest eight characters
        if (!cmp_hit && seen_cnt >= CMP_LEN) begin
            ok = 1'b1;
            for (k = 2; k < WIN; k++) begin
                if (!is_digit(win_bytes[k])) ok = 1'b0;
            end
            if (ok) begin
                y = digit_at(2) * 1000 + digit_at(3) * 100 + digit_at(4) * 10 + digit_at(5);
                m = digit_at(6) * 10 + digit_at(7);
                d = digit_at(8) * 10 + digit_at(9);
                if (y >= 1900 && y <= 2100 && m >= 1 && m <= 12 && d >= 1 && d <= 31) begin
                    cmp_hit  = 1'b1;
                    cmp_date = '{1'b1, 14'(y), 4'(m), 5'(d)};
                end
            end
        end

        res = '0;
        if (!last) return 1'b0;
        if (sep_hit) res = sep_date;
        else if (cmp_hit) res = cmp_date;
        clear_predictor();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Drive one character and hold it until the transaction completes
    task automatic send_char(input logic [7:0] c, input logic last,
                             input logic typed, input date_result_t want);
        date_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        chars_sent++;
        if (date_after_char(c, last, res)) begin
            expected_dates.insert(expected_dates.size(), typed ? want : res);
        end
    endtask

    task automatic send_name(input int len, input logic typed, input date_result_t want);
        int j;
        for (j = 0; j < len; j++) send_char(name_buf[j], j == len - 1, typed, want);
        names_sent++;
    endtask

    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) return ASC_ZERO + 8'($urandom_range(9));
        if (pick < 62) return $urandom_range(1) ? ASC_DASH : ASC_UNDER;
        if (pick < 80) return 8'($urandom_range(255));
        return ASC_LOW_A + 8'($urandom_range(25));
    endfunction

    task automatic put_digits(input int pos, input int value, input int ndig);
        int k;
        for (k = ndig - 1; k >= 0; k--) begin
            name_buf[pos + k] = ASC_ZERO + 8'(value % 10);
            value = value / 10;
        end
    endtask

    // Build a random name, most of them carrying one or two near-valid dates
    task automatic build_random_name(output int len);
        int k, pick, n, at, y, m, d, span;
        bit compact;
        pick = $urandom_range(99);
        if (pick < 10) len = $urandom_range(1, 9);
        else if (pick < 90) len = $urandom_range(8, 18);
        else len = $urandom_range(19, MAX_NAME);
        for (k = 0; k < len; k++) name_buf[k] = rand_byte();
        if (pick >= 15) begin
            n = ($urandom_range(3) == 0) ? 2 : 1;
            repeat (n) begin
                compact = $urandom_range(1);
                span = compact ? CMP_LEN : SEP_LEN;
                if (len >= span) begin
                    at = $urandom_range(0, len - span);
                    m = ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(13);
                    d = ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(32);
                    if (compact) begin
                        y = ($urandom_range(3) == 0) ? $urandom_range(9999)
                                                     : $urandom_range(1899, 2101);
                        put_digits(at, y, 4);
                        put_digits(at + 4, m, 2);
                        put_digits(at + 6, d, 2);
                    end else begin
                        y = $urandom_range(9999);
                        put_digits(at, y, 4);
                        name_buf[at + 4] = $urandom_range(1) ? ASC_DASH : ASC_UNDER;
                        put_digits(at + 5, m, 2);
                        name_buf[at + 7] = $urandom_range(1) ? ASC_DASH : ASC_UNDER;
                        put_digits(at + 8, d, 2);
                    end
                end
            end
        end
    endtask

    // Hold the sender off until every pending result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_dates.size() != 0) @(posedge i_clk);
    endtask

    // Randomize the receiver's readiness
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (o_found) dates_found++;
            if (expected_dates.size() == 0) begin
                report_mismatch("unexpected result, year", o_year, 0);
            end else begin
                mon_want = expected_dates.pop_front();
                if (o_found !== mon_want.found) report_mismatch("found", o_found, mon_want.found);
                if (o_year !== mon_want.year) report_mismatch("year", o_year, mon_want.year);
                if (o_month !== mon_want.month) report_mismatch("month", o_month, mon_want.month);
                if (o_day !== mon_want.day) report_mismatch("day", o_day, mon_want.day);
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        name_row_t row;
        int k, j, len, phase, phase_chars;
        int send_pcts [4];
        int recv_pcts [4];
        send_pcts = '{0, 52, 0, 20};
        recv_pcts = '{0, 0, 52, 20};

        // Byte extremes, both date forms at their extremes, and a short name
        dir_rows[0] = '{80'h00, 4'd1, 1'b1, '{1'b0, 14'd0, 4'd0, 5'd0}};
        dir_rows[1] = '{80'hFF, 4'd1, 1'b1, '{1'b0, 14'd0, 4'd0, 5'd0}};
        dir_rows[2] = '{80'("19000101"), 4'd8, 1'b1, '{1'b1, 14'd1900, 4'd1, 5'd1}};
        dir_rows[3] = '{80'("9999-12_31"), 4'd10, 1'b1, '{1'b1, 14'd9999, 4'd12, 5'd31}};
        dir_rows[4] = '{80'("abc"), 4'd3, 1'b1, '{1'b0, 14'd0, 4'd0, 5'd0}};

        clear_predictor();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (k = 0; k < NUM_ROWS; k++) begin
            row = dir_rows[k];
            for (j = 0; j < row.len; j++) name_buf[j] = row.text[8 * (row.len - 1 - j) +: 8];
            send_name(row.len, row.typed, row.want);
        end

        // Random names, one idle pattern per phase
        for (phase = 0; phase < 4; phase++) begin
            drain_results();
            send_idle_pct  = send_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            phase_chars = 0;
            while (phase_chars < RAND_CHARS / 4) begin
                build_random_name(len);
                send_name(len, 1'b0, '0);
                phase_chars += len;
            end
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run covered %0d names, %0d characters, %0d results, %0d with a date",
                 names_sent, chars_sent, results_seen, dates_found);
        $display("idle patterns: none, sender 52%%, receiver 52%%, both 20%%");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/fdx_pkg.sv
src/fdx_cell.sv
src/fdx_check.sv
src/filename_date_extractor_unit.sv
dv/tb.sv
